/* src/pid_with_deadband_and_clamps_top_defines.svh */
// assertion macros for the pid block
`ifndef PID_WITH_DEADBAND_AND_CLAMPS_TOP_DEFINES_SVH
`define PID_WITH_DEADBAND_AND_CLAMPS_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define PIDC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pidc assertion failed");
`define PIDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pidc assertion failed");
`else
`define PIDC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PIDC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* src/pidc_pkg.sv */
// shared types, register indexes and clamp helpers for the pid block
package pidc_pkg;

	localparam int GAIN_W  = 16;
	localparam int VAL_W   = 16;
	localparam int ERR_W   = 17;
	localparam int DELTA_W = 18;
	localparam int PTERM_W = 25;
	localparam int DTERM_W = 26;
	localparam int ITERM_W = 18;
	localparam int IACC_W  = 26;
	localparam int SUM_W   = 28;
	localparam int DRIVE_W = 17;
	localparam int IDX_W   = 3;

	localparam logic [IDX_W-1:0] REG_GAIN_P         = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_I         = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_D         = 3'd2;
	localparam logic [IDX_W-1:0] REG_DEAD_BAND      = 3'd3;
	localparam logic [IDX_W-1:0] REG_INTEGRAL_LIMIT = 3'd4;
	localparam logic [IDX_W-1:0] REG_OUTPUT_LIMIT   = 3'd5;

	typedef logic signed [VAL_W-1:0]   val_t;
	typedef logic signed [DRIVE_W-1:0] drive_t;

	// symmetric clamp of the integral accumulator
	function automatic logic signed [IACC_W-1:0] clamp_iacc(
		input logic signed [IACC_W-1:0] v,
		input logic [VAL_W-1:0] lim
	);
		logic signed [IACC_W-1:0] hi;
		logic signed [IACC_W-1:0] lo;
		hi = $signed({{(IACC_W-VAL_W){1'b0}}, lim});
		lo = -hi;
		if (v > hi)
			return hi;
		else if (v < lo)
			return lo;
		else
			return v;
	endfunction

	// symmetric clamp of the term sum
	function automatic logic signed [SUM_W-1:0] clamp_sum(
		input logic signed [SUM_W-1:0] v,
		input logic [VAL_W-1:0] lim
	);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = $signed({{(SUM_W-VAL_W){1'b0}}, lim});
		lo = -hi;
		if (v > hi)
			return hi;
		else if (v < lo)
			return lo;
		else
			return v;
	endfunction

endpackage

/* src/pidc_in_if.sv */
// input channel: setpoint and measurement
interface pidc_in_if;
	import pidc_pkg::*;

	logic valid;
	logic ready;
	val_t target_value;
	val_t measured_value;

	modport source (output valid, output target_value, output measured_value, input ready);
	modport sink (input valid, input target_value, input measured_value, output ready);
endinterface

/* src/pidc_out_if.sv */
// output channel: clamped drive and saturation flag
interface pidc_out_if;
	import pidc_pkg::*;

	logic   valid;
	logic   ready;
	drive_t drive_value;
	logic   output_saturated;

	modport source (output valid, output drive_value, output output_saturated, input ready);
	modport sink (input valid, input drive_value, input output_saturated, output ready);
endinterface

/* src/pid_with_deadband_and_clamps_top.sv */
// pid controller with deadband, integral clamp and output clamp
//
// req carries one transaction per control step: target_value and
// measured_value. rsp returns one transaction per step: drive_value, the sum
// of the p, i and d terms clamped to +/-output_limit, and output_saturated.
// gains, deadband and limits are written through cfg_wr_en/cfg_index/
// cfg_wdata while no step is in flight.
// four stages: error and deadband test, the three gain multipliers, the
// term update (the integral accumulate is the recurrence on the held
// integral term), then the sum and clamp into the result register.
// rsp.valid rises once a transaction has passed the s1 to s4 registers;
// one transaction is taken every cycle while rsp is not stalled.
// each stage holds when the one after it is full and stalled, so a stall
// on rsp fills the empty stages before req.ready drops.
// reset clears gains and deadband to zero, both limits to 65535, the held
// terms and the previous error to zero, and empties the pipeline.
`include "pid_with_deadband_and_clamps_top_defines.svh"

module pid_with_deadband_and_clamps_top (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_wr_en,
	input  logic [pidc_pkg::IDX_W-1:0]   cfg_index,
	input  logic [pidc_pkg::VAL_W-1:0]   cfg_wdata,
	pidc_in_if.sink                      req,
	pidc_out_if.source                   rsp
);
	import pidc_pkg::*;

	// configuration
	logic signed [GAIN_W-1:0] gain_p_q;
	logic signed [GAIN_W-1:0] gain_i_q;
	logic signed [GAIN_W-1:0] gain_d_q;
	logic [VAL_W-1:0]         dead_band_q;
	logic [VAL_W-1:0]         integral_limit_q;
	logic [VAL_W-1:0]         output_limit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_p_q         <= '0;
			gain_i_q         <= '0;
			gain_d_q         <= '0;
			dead_band_q      <= '0;
			integral_limit_q <= '1;
			output_limit_q   <= '1;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_GAIN_P:         gain_p_q         <= cfg_wdata;
				REG_GAIN_I:         gain_i_q         <= cfg_wdata;
				REG_GAIN_D:         gain_d_q         <= cfg_wdata;
				REG_DEAD_BAND:      dead_band_q      <= cfg_wdata;
				REG_INTEGRAL_LIMIT: integral_limit_q <= cfg_wdata;
				REG_OUTPUT_LIMIT:   output_limit_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// stage enables
	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4     = !valid_s4 || rsp.ready;
	assign en_s3     = !valid_s3 || en_s4;
	assign en_s2     = !valid_s2 || en_s3;
	assign en_s1     = !valid_s1 || en_s2;
	assign req.ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (en_s1) valid_s1 <= req.valid;
			if (en_s2) valid_s2 <= valid_s1;
			if (en_s3) valid_s3 <= valid_s2;
			if (en_s4) valid_s4 <= valid_s3;
		end
	end

	// stage 1: error, change in error, deadband test
	logic signed [ERR_W-1:0]   err;
	logic [ERR_W-1:0]          err_mag;
	logic signed [DELTA_W-1:0] delta;
	logic signed [ERR_W-1:0]   prev_error_q;
	logic signed [ERR_W-1:0]   err_s1;
	logic signed [DELTA_W-1:0] delta_s1;
	logic                      upd_s1;
	logic                      req_fire;

	assign req_fire = req.valid && en_s1;
	assign err      = $signed({req.target_value[VAL_W-1], req.target_value})
	                - $signed({req.measured_value[VAL_W-1], req.measured_value});
	assign err_mag  = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
	assign delta    = $signed({err[ERR_W-1], err}) - $signed({prev_error_q[ERR_W-1], prev_error_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_error_q <= '0;
		end else if (req_fire) begin
			prev_error_q <= err;
		end
	end

	always_ff @(posedge clk) begin
		if (req_fire) begin
			err_s1   <= err;
			delta_s1 <= delta;
			upd_s1   <= err_mag > {1'b0, dead_band_q};
		end
	end

	// stage 2: gain products, floor shift by 8
	logic signed [GAIN_W+ERR_W-1:0]   prod_p;
	logic signed [GAIN_W+ERR_W-1:0]   prod_i;
	logic signed [GAIN_W+DELTA_W-1:0] prod_d;
	logic signed [PTERM_W-1:0]        pterm_s2;
	logic signed [PTERM_W-1:0]        iinc_s2;
	logic signed [DTERM_W-1:0]        dterm_s2;
	logic                             upd_s2;

	assign prod_p = gain_p_q * err_s1;
	assign prod_i = gain_i_q * err_s1;
	assign prod_d = gain_d_q * delta_s1;

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			pterm_s2 <= prod_p[GAIN_W+ERR_W-1:8];
			iinc_s2  <= prod_i[GAIN_W+ERR_W-1:8];
			dterm_s2 <= prod_d[GAIN_W+DELTA_W-1:8];
			upd_s2   <= upd_s1;
		end
	end

	// stage 3: held terms, integral accumulate and clamp
	logic signed [PTERM_W-1:0] term_p_q;
	logic signed [ITERM_W-1:0] term_i_q;
	logic signed [DTERM_W-1:0] term_d_q;
	logic signed [IACC_W-1:0]  iacc;
	logic signed [IACC_W-1:0]  iacc_clamped;

	assign iacc = $signed({{(IACC_W-ITERM_W){term_i_q[ITERM_W-1]}}, term_i_q})
	            + (upd_s2 ? $signed({{(IACC_W-PTERM_W){iinc_s2[PTERM_W-1]}}, iinc_s2})
	                      : $signed(IACC_W'(0)));
	assign iacc_clamped = clamp_iacc(iacc, integral_limit_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			term_p_q <= '0;
			term_i_q <= '0;
			term_d_q <= '0;
		end else if (en_s3 && valid_s2) begin
			if (upd_s2) begin
				term_p_q <= pterm_s2;
				term_d_q <= dterm_s2;
			end
			term_i_q <= iacc_clamped[ITERM_W-1:0];
		end
	end

	// stage 4: sum, output clamp, result register
	logic signed [SUM_W-1:0] sum;
	logic signed [SUM_W-1:0] sum_clamped;
	drive_t                  drive_s4;
	logic                    sat_s4;

	assign sum = $signed({{(SUM_W-PTERM_W){term_p_q[PTERM_W-1]}}, term_p_q})
	           + $signed({{(SUM_W-ITERM_W){term_i_q[ITERM_W-1]}}, term_i_q})
	           + $signed({{(SUM_W-DTERM_W){term_d_q[DTERM_W-1]}}, term_d_q});
	assign sum_clamped = clamp_sum(sum, output_limit_q);

	always_ff @(posedge clk) begin
		if (en_s4 && valid_s3) begin
			drive_s4 <= sum_clamped[DRIVE_W-1:0];
			sat_s4   <= sum_clamped != sum;
		end
	end

	assign rsp.valid            = valid_s4;
	assign rsp.drive_value      = drive_s4;
	assign rsp.output_saturated = sat_s4;

	// checks
	logic signed [DRIVE_W-1:0] olim_pos;
	logic signed [ITERM_W-1:0] ilim_pos;
	logic [ERR_W-1:0]          err_s1_mag;

	assign olim_pos   = $signed({1'b0, output_limit_q});
	assign ilim_pos   = $signed({2'b00, integral_limit_q});
	assign err_s1_mag = err_s1[ERR_W-1] ? ERR_W'(-err_s1) : ERR_W'(err_s1);

	`PIDC_ASSERT_IMPL(a_iterm_in_limit, clk, arst_n, valid_s3,
		term_i_q <= ilim_pos && term_i_q >= -ilim_pos)
	`PIDC_ASSERT_IMPL(a_sat_at_limit, clk, arst_n, valid_s4 && sat_s4,
		drive_s4 == olim_pos || drive_s4 == -olim_pos)
	`PIDC_ASSERT_IMPL(a_hold_in_deadband, clk, arst_n, valid_s1 && !upd_s1,
		err_s1_mag <= {1'b0, dead_band_q})
	`PIDC_ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, req.valid && req.ready, valid_s1)

endmodule
